### rtl/core/sst_pkg.sv
// Shared constants and types for the sorted sensor record table.
`timescale 1ns / 1ps

package sst_pkg;

  // Table geometry
  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 8;
  localparam int KEY_W    = 8;
  localparam int PAY_W    = 32;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Significant id bits
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  // Command and status codes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } cmd_t;

  // Head of the command queue as the back end sees it
  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } q_head_t;

endpackage

### rtl/core/sst_front.sv
// Command intake: accepts words, masks the id, and buffers them in a short queue.
`timescale 1ns / 1ps

module sst_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     mode,
  input  logic [sst_pkg::KEY_W-1:0] sensor_key,
  input  logic [sst_pkg::PAY_W-1:0] payload_in,
  input  logic                     pop,
  output logic                     busy,
  output sst_pkg::q_head_t         head
);

  sst_pkg::cmd_t                   q [sst_pkg::QDEPTH];
  sst_pkg::cmd_t                   incoming;
  logic [sst_pkg::QPTR_W-1:0]      wr_ptr;
  logic [sst_pkg::QPTR_W-1:0]      rd_ptr;
  logic [sst_pkg::QCNT_W-1:0]      count;
  logic                            push;

  // Accept when a slot is free
  assign busy = (count == sst_pkg::QCNT_W'(sst_pkg::QDEPTH));
  assign push = start && !busy;

  // Classify and clean up the incoming word
  always_comb begin
    incoming.mode    = (mode == sst_pkg::MODE_INSERT) ? sst_pkg::MODE_INSERT
                                                      : sst_pkg::MODE_LOOKUP;
    incoming.key     = sensor_key & sst_pkg::KEY_MASK;
    incoming.payload = payload_in;
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        if (wr_ptr == sst_pkg::QPTR_W'(sst_pkg::QDEPTH - 1)) wr_ptr <= '0;
        else wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        if (rd_ptr == sst_pkg::QPTR_W'(sst_pkg::QDEPTH - 1)) rd_ptr <= '0;
        else rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= incoming;
  end

  assign head.avail = (count != '0);
  assign head.cmd   = q[rd_ptr];

endmodule

### rtl/core/sst_back.sv
// Table engine: parallel compare of all slots, then lookup select or shifted insert.
`timescale 1ns / 1ps

module sst_back (
  input  logic                      clk,
  input  logic                      rst,
  input  sst_pkg::q_head_t          head,
  output logic                      pop,
  output logic                      done,
  output logic                      found,
  output logic [sst_pkg::KEY_W-1:0] key_out,
  output logic [sst_pkg::PAY_W-1:0] payload_out,
  output logic                      status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                            state;
  logic [sst_pkg::KEY_W-1:0]       ekey [sst_pkg::ENTRIES];
  logic [sst_pkg::PAY_W-1:0]       epay [sst_pkg::ENTRIES];
  logic [sst_pkg::ENTRIES-1:0]     eact;
  logic [sst_pkg::CNT_W-1:0]       count;

  sst_pkg::cmd_t                   cur;
  logic [sst_pkg::ENTRIES-1:0]     hit;
  logic [sst_pkg::ENTRIES-1:0]     le;
  logic [sst_pkg::ENTRIES-1:0]     hit_next;
  logic [sst_pkg::ENTRIES-1:0]     le_next;

  logic [sst_pkg::ENTRIES-1:0]     first_hit;
  logic [sst_pkg::ENTRIES-1:0]     prev_le;
  logic [sst_pkg::ENTRIES-1:0]     take_new;
  logic [sst_pkg::KEY_W-1:0]       prv_key [sst_pkg::ENTRIES];
  logic [sst_pkg::PAY_W-1:0]       prv_pay [sst_pkg::ENTRIES];
  logic [sst_pkg::ENTRIES-1:0]     prv_act;
  logic [sst_pkg::PAY_W-1:0]       sel_pay;
  logic                            full;
  logic                            do_ins;

  assign pop = (state == ST_IDLE) && head.avail;

  // Compare every slot against the queued id
  always_comb begin
    for (int i = 0; i < sst_pkg::ENTRIES; i++) begin
      hit_next[i] = eact[i] && (ekey[i] == head.cmd.key);
      le_next[i]  = eact[i] && (ekey[i] <= head.cmd.key);
    end
  end

  // Lookup: lowest matching slot wins
  assign first_hit = hit & (~hit + 1'b1);
  always_comb begin
    sel_pay = '0;
    for (int i = 0; i < sst_pkg::ENTRIES; i++) begin
      if (first_hit[i]) sel_pay = sel_pay | epay[i];
    end
  end

  // Insert: slots with id <= new id hold, the first other slot takes the
  // new record, the rest move up by one
  assign full     = (count == sst_pkg::CNT_W'(sst_pkg::ENTRIES));
  assign do_ins   = (cur.mode == sst_pkg::MODE_INSERT) && !full;
  assign prev_le  = {le[sst_pkg::ENTRIES-2:0], 1'b1};
  assign take_new = ~le & prev_le;

  always_comb begin
    prv_key[0] = ekey[0];
    prv_pay[0] = epay[0];
    prv_act[0] = eact[0];
    for (int i = 1; i < sst_pkg::ENTRIES; i++) begin
      prv_key[i] = ekey[i-1];
      prv_pay[i] = epay[i-1];
      prv_act[i] = eact[i-1];
    end
  end

  // Sequencer, valid bits, fill count, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      eact  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (pop) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          if (do_ins) begin
            count <= count + 1'b1;
            for (int i = 0; i < sst_pkg::ENTRIES; i++) begin
              if (take_new[i]) eact[i] <= 1'b1;
              else if (!le[i]) eact[i] <= prv_act[i];
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  // Captured command and compare vectors
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.cmd;
      hit <= hit_next;
      le  <= le_next;
    end
  end

  // Record storage
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && do_ins) begin
      for (int i = 0; i < sst_pkg::ENTRIES; i++) begin
        if (take_new[i]) begin
          ekey[i] <= cur.key;
          epay[i] <= cur.payload;
        end else if (!le[i]) begin
          ekey[i] <= prv_key[i];
          epay[i] <= prv_pay[i];
        end
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      found       <= (cur.mode == sst_pkg::MODE_LOOKUP) && (|hit);
      key_out     <= cur.key;
      payload_out <= (cur.mode == sst_pkg::MODE_LOOKUP) ? sel_pay : '0;
      status      <= ((cur.mode == sst_pkg::MODE_INSERT) && full) ? sst_pkg::STATUS_FULL
                                                                  : sst_pkg::STATUS_OK;
    end
  end

endmodule

### rtl/core/sorted_sensor_record_table_top.sv
// Top level of the sorted sensor record table.
//
// A table of 16 records (8-bit id, 32-bit payload) kept in ascending id order.
// Command channel: a word (mode, sensor_key, payload_in) is taken at a rising
// edge where start is high and busy is low. mode 0 looks an id up, mode 1
// inserts a record after all records with an equal or smaller id.
// Result channel: each command gives one word on found, key_out, payload_out
// and status, shown for exactly one cycle with done high. The receiver
// cannot stall; results must be taken as they appear.
// Once the engine is free, an accepted command passes the queue, the captured
// compare vectors and the result registers before done rises. The engine takes
// no new command until the last is through; it compares all slots while a
// command is at the queue head and updates them in the next cycle. A two-word
// command queue sits in front of the engine; busy is high while it is full.
// Reset (rst, synchronous) empties the queue and marks every slot inactive.
// An insert into a full table returns status 1 and changes nothing.
`timescale 1ns / 1ps

module sorted_sensor_record_table_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode,
  input  logic [sst_pkg::KEY_W-1:0] sensor_key,
  input  logic [sst_pkg::PAY_W-1:0] payload_in,
  output logic                      done,
  output logic                      found,
  output logic [sst_pkg::KEY_W-1:0] key_out,
  output logic [sst_pkg::PAY_W-1:0] payload_out,
  output logic                      status
);

  sst_pkg::q_head_t head;
  logic             pop;

  sst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .sensor_key (sensor_key),
    .payload_in (payload_in),
    .pop        (pop),
    .busy       (busy),
    .head       (head)
  );

  sst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .done        (done),
    .found       (found),
    .key_out     (key_out),
    .payload_out (payload_out),
    .status      (status)
  );

endmodule

### rtl/core/sst_checker.sv
// Port-level checks for the sorted sensor record table, bound to the top level.
`timescale 1ns / 1ps

module sst_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      done,
  input logic                      found,
  input logic [sst_pkg::PAY_W-1:0] payload_out,
  input logic                      status
);

  // No result right after reset
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // The engine returns to idle after each command, so strobes never touch
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

  // A refused insert never reports a match
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && status == sst_pkg::STATUS_FULL) |-> !found)
    else $error("full status with found set");

  // Miss or insert carries a zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (payload_out == '0))
    else $error("nonzero payload without a match");

endmodule

bind sorted_sensor_record_table_top sst_checker u_sst_checker (
  .clk         (clk),
  .rst         (rst),
  .done        (done),
  .found       (found),
  .payload_out (payload_out),
  .status      (status)
);
